@@ design/acf_pkg.sv @@
package acf_pkg;

  localparam int unsigned HdrBytes = 4;
  localparam int unsigned MaxBytes = 7;
  localparam int unsigned LenBytes = 3;

  localparam logic [16:0] CapacityReset = 17'd65544;

  localparam logic [16:0] ShortLeMax   = 17'd256;
  localparam logic [16:0] ExtLeMax     = 17'd65536;
  localparam logic [15:0] ShortLcLimit = 16'd256;

  // frame sizes and overheads for each encoding case
  localparam logic [16:0] NeedHdrOnly    = 17'd4;
  localparam logic [16:0] NeedShortLe    = 17'd5;
  localparam logic [16:0] NeedExtLe      = 17'd7;
  localparam logic [16:0] OvhShortLc     = 17'd5;
  localparam logic [16:0] OvhExtLc       = 17'd7;
  localparam logic [16:0] OvhShortLcLe   = 17'd6;
  localparam logic [16:0] OvhExtLcLe     = 17'd9;

  localparam logic ReqStart = 1'b0;
  localparam logic ReqData  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BUF_SHORT = 2'd1,
    ST_LE_RANGE  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    TF_NONE  = 2'd0,
    TF_SHORT = 2'd1,
    TF_EXT   = 2'd2
  } trailer_e;

  typedef logic [2:0] byte_cnt_t;

  // one queued job: up to seven bytes to emit, first byte in bytes[0]
  typedef struct packed {
    logic [MaxBytes-1:0][7:0] bytes;
    byte_cnt_t                count;
    logic                     last;
    status_e                  status;
    logic [16:0]              frame_length;
  } job_t;

endpackage

@@ design/acf_front.sv @@
module acf_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_wr_en_i,
  input  logic [16:0]   cfg_wr_data_i,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic          req_type_i,
  input  logic [31:0]   header_word_i,
  input  logic [15:0]   data_count_i,
  input  logic [16:0]   expected_count_i,
  input  logic [7:0]    data_value_i,
  input  logic          q_full_i,
  output logic          push_o,
  output acf_pkg::job_t job_o
);
  import acf_pkg::*;

  logic [16:0] capacity_q;
  logic [15:0] data_left_q, data_left_d;
  logic [16:0] saved_le_q, saved_le_d;
  trailer_e    tf_q, tf_d;
  logic        discarding_q, discarding_d;
  logic [16:0] saved_fl_q, saved_fl_d;

  logic                    accept;
  logic                    lc_zero, le_zero;
  logic [16:0]             need;
  logic [LenBytes-1:0][7:0] lb;
  logic [1:0]              nl;
  trailer_e                tf;
  logic                    lechk;
  status_e                 st;
  logic [15:0]             dl_dec;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign lc_zero    = (data_count_i == '0);
  assign le_zero    = (expected_count_i == '0);
  assign dl_dec     = data_left_q - 16'd1;

  // pick header only, short or extended length bytes from lc and le
  always_comb begin
    need  = NeedHdrOnly;
    lb    = '0;
    nl    = 2'd0;
    tf    = TF_NONE;
    lechk = 1'b0;
    if (lc_zero) begin
      if (le_zero) begin
        need = NeedHdrOnly;
      end else if (expected_count_i <= ShortLeMax) begin
        need  = NeedShortLe;
        lb[0] = expected_count_i[7:0];
        nl    = 2'd1;
      end else begin
        need  = NeedExtLe;
        lechk = 1'b1;
        lb[1] = expected_count_i[15:8];
        lb[2] = expected_count_i[7:0];
        nl    = 2'd3;
      end
    end else if (le_zero) begin
      if (data_count_i < ShortLcLimit) begin
        need  = {1'b0, data_count_i} + OvhShortLc;
        lb[0] = data_count_i[7:0];
        nl    = 2'd1;
      end else begin
        need  = {1'b0, data_count_i} + OvhExtLc;
        lb[1] = data_count_i[15:8];
        lb[2] = data_count_i[7:0];
        nl    = 2'd3;
      end
    end else if (data_count_i < ShortLcLimit && expected_count_i <= ShortLeMax) begin
      need  = {1'b0, data_count_i} + OvhShortLcLe;
      lb[0] = data_count_i[7:0];
      nl    = 2'd1;
      tf    = TF_SHORT;
    end else begin
      need  = {1'b0, data_count_i} + OvhExtLcLe;
      lechk = 1'b1;
      lb[1] = data_count_i[15:8];
      lb[2] = data_count_i[7:0];
      nl    = 2'd3;
      tf    = TF_EXT;
    end

    // buffer check wins over the le range check
    if (capacity_q < need) begin
      st = ST_BUF_SHORT;
    end else if (lechk && expected_count_i > ExtLeMax) begin
      st = ST_LE_RANGE;
    end else begin
      st = ST_OK;
    end
  end

  always_comb begin
    data_left_d  = data_left_q;
    saved_le_d   = saved_le_q;
    tf_d         = tf_q;
    discarding_d = discarding_q;
    saved_fl_d   = saved_fl_q;
    push_o       = 1'b0;
    job_o        = '0;
    if (accept) begin
      if (req_type_i == ReqStart) begin
        // a new start abandons whatever command was open
        data_left_d  = data_count_i;
        discarding_d = (st != ST_OK) && !lc_zero;
        tf_d         = TF_NONE;
        saved_le_d   = '0;
        saved_fl_d   = '0;
        push_o       = 1'b1;
        if (st != ST_OK) begin
          job_o.count  = 3'd1;
          job_o.last   = 1'b1;
          job_o.status = st;
        end else begin
          for (int i = 0; i < HdrBytes; i++) begin
            job_o.bytes[i] = header_word_i[8*(HdrBytes-1-i) +: 8];
          end
          for (int i = 0; i < LenBytes; i++) begin
            job_o.bytes[HdrBytes+i] = lb[i];
          end
          job_o.count        = 3'(HdrBytes) + {1'b0, nl};
          job_o.last         = lc_zero;
          job_o.frame_length = need;
          if (!lc_zero) begin
            saved_le_d = expected_count_i;
            tf_d       = tf;
            saved_fl_d = need;
          end
        end
      end else if (data_left_q != '0) begin
        data_left_d = dl_dec;
        if (discarding_q) begin
          if (dl_dec == '0) begin
            discarding_d = 1'b0;
          end
        end else begin
          push_o         = 1'b1;
          job_o.bytes[0] = data_value_i;
          job_o.count    = 3'd1;
          if (dl_dec == '0) begin
            // last data byte drags the le trailer along
            tf_d               = TF_NONE;
            job_o.last         = 1'b1;
            job_o.frame_length = saved_fl_q;
            case (tf_q)
              TF_SHORT: begin
                job_o.bytes[1] = saved_le_q[7:0];
                job_o.count    = 3'd2;
              end
              TF_EXT: begin
                job_o.bytes[1] = saved_le_q[15:8];
                job_o.bytes[2] = saved_le_q[7:0];
                job_o.count    = 3'd3;
              end
              default: ;
            endcase
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q   <= CapacityReset;
      data_left_q  <= '0;
      saved_le_q   <= '0;
      tf_q         <= TF_NONE;
      discarding_q <= 1'b0;
      saved_fl_q   <= '0;
    end else begin
      if (cfg_wr_en_i) begin
        capacity_q <= cfg_wr_data_i;
      end
      data_left_q  <= data_left_d;
      saved_le_q   <= saved_le_d;
      tf_q         <= tf_d;
      discarding_q <= discarding_d;
      saved_fl_q   <= saved_fl_d;
    end
  end

endmodule

@@ design/acf_queue.sv @@
module acf_queue #(
  parameter int unsigned Depth = 4
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  acf_pkg::job_t push_data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output acf_pkg::job_t head_o
);
  import acf_pkg::*;

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  job_t            entry_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign head_o  = entry_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

@@ design/acf_back.sv @@
module acf_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             head_valid_i,
  input  acf_pkg::job_t    head_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [7:0]       out_byte_o,
  output logic             last_o,
  output acf_pkg::status_e status_o,
  output logic [16:0]      frame_length_o
);
  import acf_pkg::*;

  byte_cnt_t   idx_q;
  logic        valid_q;
  logic [7:0]  byte_q;
  logic        last_q;
  status_e     status_q;
  logic [16:0] fl_q;

  logic load, fin;

  // output register frees up either when empty or when its transfer completes
  assign load  = head_valid_i && (!valid_q || out_ready_i);
  assign fin   = (idx_q == head_i.count - 3'd1);
  assign pop_o = load && fin;

  assign out_valid_o    = valid_q;
  assign out_byte_o     = byte_q;
  assign last_o         = last_q;
  assign status_o       = status_q;
  assign frame_length_o = fl_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q    <= '0;
      valid_q  <= 1'b0;
      byte_q   <= '0;
      last_q   <= 1'b0;
      status_q <= ST_OK;
      fl_q     <= '0;
    end else if (load) begin
      valid_q  <= 1'b1;
      byte_q   <= head_i.bytes[idx_q];
      last_q   <= fin && head_i.last;
      status_q <= fin ? head_i.status : ST_OK;
      fl_q     <= (fin && head_i.last) ? head_i.frame_length : '0;
      idx_q    <= fin ? '0 : idx_q + 3'd1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

endmodule

@@ design/apdu_command_framer_core.sv @@
// channel    | dir | fields
// -----------+-----+---------------------------------------------------------
// s_axis     | in  | tuser: req_type; tdata: header_word, data_count,
//            |     |   expected_count, data_value
// m_axis     | out | tlast: last; tuser: status; tdata: out_byte, frame_length
// cfg_wr     | in  | buffer_capacity, written when cfg_wr_en_i is high
//
// every input transfer is classified combinationally, and each one that yields
// bytes lands in a job queue of QueueDepth entries; the back end emits one byte
// per cycle from it while m_axis_tready is high. a kept data byte yields one
// output byte (two or three for the last one with le), a start item 1 to 7.
// s_axis_tready drops only while the job queue is full.
// reset is asynchronous, active low; buffer_capacity resets to 65544.
module apdu_command_framer_core #(
  parameter int unsigned QueueDepth = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_wr_en_i,
  input  logic [16:0] cfg_wr_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [31:0] header_word, [47:32] data_count, [64:48] expected_count,
  // [72:65] data_value, [79:73] zero
  input  logic [79:0] s_axis_tdata,
  // [0] req_type
  input  logic        s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] out_byte, [24:8] frame_length, [31:25] zero
  output logic [31:0] m_axis_tdata,
  // [1:0] status
  output logic [1:0]  m_axis_tuser,
  output logic        m_axis_tlast
);
  import acf_pkg::*;

  logic        q_full, q_push, q_valid, q_pop;
  job_t        push_job, head_job;
  logic [7:0]  out_byte;
  logic [16:0] frame_length;
  status_e     status;

  acf_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_wr_en_i      (cfg_wr_en_i),
    .cfg_wr_data_i    (cfg_wr_data_i),
    .in_valid_i       (s_axis_tvalid),
    .in_ready_o       (s_axis_tready),
    .req_type_i       (s_axis_tuser),
    .header_word_i    (s_axis_tdata[31:0]),
    .data_count_i     (s_axis_tdata[47:32]),
    .expected_count_i (s_axis_tdata[64:48]),
    .data_value_i     (s_axis_tdata[72:65]),
    .q_full_i         (q_full),
    .push_o           (q_push),
    .job_o            (push_job)
  );

  acf_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (push_job),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .head_o      (head_job)
  );

  acf_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .head_valid_i   (q_valid),
    .head_i         (head_job),
    .pop_o          (q_pop),
    .out_valid_o    (m_axis_tvalid),
    .out_ready_i    (m_axis_tready),
    .out_byte_o     (out_byte),
    .last_o         (m_axis_tlast),
    .status_o       (status),
    .frame_length_o (frame_length)
  );

  assign m_axis_tdata = {7'd0, frame_length, out_byte};
  assign m_axis_tuser = status;

  // non-final bytes never carry status or a frame length
  a_nonlast_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tlast |->
      m_axis_tuser == ST_OK && m_axis_tdata[24:8] == '0)
    else $error("non-final byte carries status or frame length");

  // an error result is a single zero byte that closes the command
  a_error_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser != ST_OK |->
      m_axis_tlast && m_axis_tdata[7:0] == '0 && m_axis_tdata[24:8] == '0)
    else $error("error result malformed");

  // a job written into the queue is visible to the back end next cycle
  a_push_visible: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push && !q_full |=> q_valid)
    else $error("queued job lost");

endmodule

@@ sim/tb_apdu_command_framer_core.sv @@
module tb_apdu_command_framer_core;
  timeunit 1ns;
  timeprecision 1ps;

  import acf_pkg::*;

  localparam int CycleLimit   = 400000;
  localparam int HoldCycles   = 120;
  localparam int SettleCycles = 40;
  localparam int TailCycles   = 40;

  typedef struct packed {
    logic [7:0]  octet;
    logic        last;
    status_e     st;
    logic [16:0] flen;
  } frame_byte_t;

  typedef enum logic { ROW_SEND, ROW_CFG } row_e;

  // n_typed: -1 takes the predictor, 0 or 1 takes the typed-in result
  // on a ROW_CFG row the le field carries the buffer capacity
  typedef struct packed {
    row_e        kind;
    logic        req;
    logic [31:0] hw;
    logic [15:0] lc;
    logic [16:0] le;
    logic [7:0]  dv;
    int          n_typed;
    frame_byte_t typed;
  } row_t;

  localparam frame_byte_t NoByte = '{8'h00, 1'b0, ST_OK, 17'd0};
  localparam frame_byte_t ErrBuf = '{8'h00, 1'b1, ST_BUF_SHORT, 17'd0};
  localparam frame_byte_t ErrLe  = '{8'h00, 1'b1, ST_LE_RANGE, 17'd0};

  localparam int NumRows = 28;

  row_t script [NumRows] = '{
    '{ROW_SEND, ReqData,  32'h0000_0000, 16'd0,     17'd0,      8'hFF, 0,  NoByte},
    '{ROW_SEND, ReqStart, 32'hFFFF_FFFF, 16'd0,     17'd0,      8'h00, -1, NoByte},
    '{ROW_SEND, ReqStart, 32'h0000_0000, 16'd0,     17'd256,    8'h00, -1, NoByte},
    '{ROW_SEND, ReqStart, 32'h80FF_0102, 16'd0,     17'd257,    8'h00, -1, NoByte},
    '{ROW_SEND, ReqStart, 32'hC0A4_0400, 16'd0,     17'd65536,  8'h00, -1, NoByte},
    '{ROW_SEND, ReqStart, 32'h00B0_0000, 16'd0,     17'd65537,  8'h00, 1,  ErrLe},
    '{ROW_SEND, ReqStart, 32'h00DA_0001, 16'd1,     17'd0,      8'h00, -1, NoByte},
    '{ROW_SEND, ReqData,  32'h0000_0000, 16'd0,     17'd0,      8'h00, -1, NoByte},
    '{ROW_SEND, ReqStart, 32'h00A4_0400, 16'd2,     17'd256,    8'h00, -1, NoByte},
    '{ROW_SEND, ReqData,  32'h0000_0000, 16'd0,     17'd0,      8'hFF, -1, NoByte},
    '{ROW_SEND, ReqData,  32'h0000_0000, 16'd0,     17'd0,      8'h5A, -1, NoByte},
    '{ROW_SEND, ReqStart, 32'h80CA_9F7F, 16'd1,     17'd257,    8'h00, -1, NoByte},
    '{ROW_SEND, ReqData,  32'h0000_0000, 16'd0,     17'd0,      8'h81, -1, NoByte},
    '{ROW_SEND, ReqStart, 32'h8482_0000, 16'd1,     17'd65537,  8'h00, 1,  ErrLe},
    '{ROW_SEND, ReqData,  32'h0000_0000, 16'd0,     17'd0,      8'h3C, 0,  NoByte},
    '{ROW_SEND, ReqStart, 32'h00D6_0000, 16'd65535, 17'd0,      8'h00, -1, NoByte},
    '{ROW_SEND, ReqStart, 32'h00D6_0000, 16'd65535, 17'd65536,  8'h00, -1, NoByte},
    '{ROW_SEND, ReqStart, 32'h00D6_0000, 16'd65535, 17'd131071, 8'h00, 1,  ErrLe},
    '{ROW_SEND, ReqStart, 32'h0020_0080, 16'd3,     17'd255,    8'h00, -1, NoByte},
    '{ROW_SEND, ReqData,  32'h0000_0000, 16'd0,     17'd0,      8'h01, -1, NoByte},
    '{ROW_CFG,  ReqStart, 32'h0000_0000, 16'd0,     17'd5,      8'h00, -1, NoByte},
    '{ROW_SEND, ReqStart, 32'hFFFF_FFFF, 16'd0,     17'd1,      8'h00, -1, NoByte},
    '{ROW_SEND, ReqStart, 32'h0000_0000, 16'd0,     17'd131071, 8'h00, 1,  ErrBuf},
    '{ROW_SEND, ReqStart, 32'h7F00_0000, 16'd2,     17'd0,      8'h00, 1,  ErrBuf},
    '{ROW_SEND, ReqData,  32'h0000_0000, 16'd0,     17'd0,      8'hA5, 0,  NoByte},
    '{ROW_SEND, ReqData,  32'h0000_0000, 16'd0,     17'd0,      8'hC3, 0,  NoByte},
    '{ROW_CFG,  ReqStart, 32'h0000_0000, 16'd0,     17'd0,      8'h00, -1, NoByte},
    '{ROW_SEND, ReqStart, 32'h0000_0000, 16'd0,     17'd0,      8'h00, 1,  ErrBuf}
  };

  logic        clk_i          = 1'b0;
  logic        rst_ni         = 1'b0;
  logic        cfg_wr_en_i    = 1'b0;
  logic [16:0] cfg_wr_data_i  = '0;
  logic        s_axis_tvalid  = 1'b0;
  logic        s_axis_tready;
  logic [79:0] s_axis_tdata   = '0;
  logic        s_axis_tuser   = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready  = 1'b0;
  logic [31:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;

  // typed-in expectation travels with the transfer it belongs to
  int          override_n    = -1;
  frame_byte_t override_byte = NoByte;

  // predictor state
  logic [16:0] cap_reg   = CapacityReset;
  logic [15:0] data_due  = '0;
  logic [16:0] le_held   = '0;
  trailer_e    tail_kind = TF_NONE;
  logic        dropping  = 1'b0;
  logic [16:0] len_held  = '0;

  frame_byte_t frame_due_q[$];
  frame_byte_t step_bytes[$];

  int cycle_cnt    = 0;
  int mismatch_cnt = 0;
  int n_in = 0, n_out = 0, n_starts = 0, n_errors = 0, n_cfg = 0;
  int burst_left   = 0;
  int phase_items  = 0;
  int hold_req     = 0;
  bit sender_gaps  = 1'b1;

  apdu_command_framer_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_wr_en_i   (cfg_wr_en_i),
    .cfg_wr_data_i (cfg_wr_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic void emit(logic [7:0] octet, logic last, status_e st, logic [16:0] flen);
    frame_byte_t fb;
    fb = '{octet, last, st, flen};
    step_bytes.push_back(fb);
  endfunction

  task automatic frame_apdu(input logic req, input logic [31:0] hdr, input logic [15:0] lc,
                            input logic [16:0] le, input logic [7:0] dbyte);
    logic [7:0]  lenb [3];
    int          nlen;
    int          i;
    trailer_e    tail;
    int unsigned need;
    bit          le_ext;
    bit          fin;
    status_e     st;
    if (req == ReqStart) begin
      n_starts++;
      data_due  = '0;
      dropping  = 1'b0;
      tail_kind = TF_NONE;
      le_held   = '0;
      len_held  = '0;
      lenb[0] = 8'h00;
      lenb[1] = 8'h00;
      lenb[2] = 8'h00;
      nlen   = 0;
      tail   = TF_NONE;
      le_ext = 1'b0;
      st     = ST_OK;
      if (lc == 0) begin
        if (le == 0) begin
          need = 4;
        end else if (le <= 256) begin
          need = 5; lenb[0] = le[7:0]; nlen = 1;
        end else begin
          need = 7; le_ext = 1'b1; lenb[1] = le[15:8]; lenb[2] = le[7:0]; nlen = 3;
        end
      end else if (le == 0) begin
        if (lc < 256) begin
          need = 5 + lc; lenb[0] = lc[7:0]; nlen = 1;
        end else begin
          need = 7 + lc; lenb[1] = lc[15:8]; lenb[2] = lc[7:0]; nlen = 3;
        end
      end else if (lc < 256 && le <= 256) begin
        need = 6 + lc; lenb[0] = lc[7:0]; nlen = 1; tail = TF_SHORT;
      end else begin
        need = 9 + lc; le_ext = 1'b1; lenb[1] = lc[15:8]; lenb[2] = lc[7:0]; nlen = 3;
        tail = TF_EXT;
      end
      // capacity is checked ahead of the le range
      if (cap_reg < need) st = ST_BUF_SHORT;
      else if (le_ext && le > 65536) st = ST_LE_RANGE;
      if (st != ST_OK) begin
        n_errors++;
        emit(8'h00, 1'b1, st, 17'd0);
        if (lc != 0) begin
          dropping = 1'b1;
          data_due = lc;
        end
      end else begin
        for (i = 0; i < 4; i++) begin
          fin = (lc == 0 && nlen == 0 && i == 3);
          emit(hdr[31-8*i -: 8], fin, ST_OK, fin ? 17'(need) : 17'd0);
        end
        for (i = 0; i < nlen; i++) begin
          fin = (lc == 0 && i + 1 == nlen);
          emit(lenb[i], fin, ST_OK, fin ? 17'(need) : 17'd0);
        end
        if (lc != 0) begin
          data_due  = lc;
          le_held   = le;
          tail_kind = tail;
          len_held  = 17'(need);
        end
      end
    end else if (data_due != 0) begin
      data_due--;
      if (dropping) begin
        if (data_due == 0) dropping = 1'b0;
      end else if (data_due != 0) begin
        emit(dbyte, 1'b0, ST_OK, 17'd0);
      end else begin
        tail      = tail_kind;
        tail_kind = TF_NONE;
        case (tail)
          TF_SHORT: begin
            emit(dbyte, 1'b0, ST_OK, 17'd0);
            emit(le_held[7:0], 1'b1, ST_OK, len_held);
          end
          TF_EXT: begin
            emit(dbyte, 1'b0, ST_OK, 17'd0);
            emit(le_held[15:8], 1'b0, ST_OK, 17'd0);
            emit(le_held[7:0], 1'b1, ST_OK, len_held);
          end
          default: emit(dbyte, 1'b1, ST_OK, len_held);
        endcase
      end
    end
  endtask

  function automatic void note_mismatch(string what, frame_byte_t want, frame_byte_t got);
    mismatch_cnt++;
    if (mismatch_cnt <= 10)
      $display("mismatch %s @%0d: exp %02h l%0b s%0d n%0d, got %02h l%0b s%0d n%0d",
               what, cycle_cnt, want.octet, want.last, want.st, want.flen,
               got.octet, got.last, got.st, got.flen);
  endfunction

  // checks output transfers first, then predicts from the input transfer of the same edge
  always @(posedge clk_i) begin
    frame_byte_t got;
    frame_byte_t want;
    cycle_cnt++;
    if (rst_ni) begin
      if (cfg_wr_en_i) cap_reg = cfg_wr_data_i;
      if (m_axis_tvalid === 1'b1 && m_axis_tready) begin
        got = '{m_axis_tdata[7:0], m_axis_tlast, status_e'(m_axis_tuser), m_axis_tdata[24:8]};
        n_out++;
        if (frame_due_q.size() == 0) begin
          note_mismatch("nothing pending", NoByte, got);
        end else begin
          want = frame_due_q.pop_front();
          if (got.octet !== want.octet || got.last !== want.last ||
              got.st !== want.st || got.flen !== want.flen)
            note_mismatch("wrong field", want, got);
        end
      end
      if (s_axis_tvalid && s_axis_tready === 1'b1) begin
        n_in++;
        step_bytes.delete();
        frame_apdu(s_axis_tuser, s_axis_tdata[31:0], s_axis_tdata[47:32],
                   s_axis_tdata[64:48], s_axis_tdata[72:65]);
        if (override_n < 0) begin
          foreach (step_bytes[i]) frame_due_q.push_back(step_bytes[i]);
        end else if (override_n > 0) begin
          frame_due_q.push_back(override_byte);
        end
      end
    end
  end

  // receiver: rotating ready pattern, reloaded now and then, plus long hold-offs on request
  initial begin
    logic [15:0] pat;
    int          tick;
    int          hold_seen;
    pat       = '1;
    tick      = 0;
    hold_seen = 0;
    forever begin
      @(posedge clk_i);
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        m_axis_tready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
      end else begin
        if (tick % 48 == 0) begin
          case ($urandom_range(0, 3))
            0: pat = '1;
            1: pat = 16'($urandom) | 16'h0101;
            2: pat = 16'($urandom) | 16'($urandom) | 16'h0001;
            default: pat = 16'($urandom) & 16'($urandom) | 16'h0001;
          endcase
        end
        m_axis_tready <= pat[0];
        pat = {pat[0], pat[15:1]};
        tick++;
      end
    end
  end

  initial begin
    while (cycle_cnt < CycleLimit) @(posedge clk_i);
    $display("FAIL");
    $finish;
  end

  task automatic offer(input logic req, input logic [31:0] hw, input logic [15:0] lc,
                       input logic [16:0] le, input logic [7:0] dv,
                       input int n_typed, input frame_byte_t typed);
    int gap;
    if (burst_left == 0) begin
      gap        = sender_gaps ? $urandom_range(0, 6) : 0;
      burst_left = $urandom_range(1, 12);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= req;
    s_axis_tdata  <= {7'd0, dv, le, lc, hw};
    override_n    <= n_typed;
    override_byte <= typed;
    do @(posedge clk_i); while (s_axis_tready !== 1'b1);
  endtask

  // waits until every expected byte is out, then lets the block go quiet
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    do @(posedge clk_i); while (frame_due_q.size() != 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_capacity(input logic [16:0] cap);
    cfg_wr_en_i   <= 1'b1;
    cfg_wr_data_i <= cap;
    @(posedge clk_i);
    cfg_wr_en_i   <= 1'b0;
    n_cfg++;
  endtask

  // lc_pick < 0 draws a random, mostly short, data length
  task automatic send_command(input int lc_pick);
    logic [15:0] lc;
    logic [16:0] le;
    int          n_data;
    int          k;
    if (lc_pick >= 0) begin
      lc = 16'(lc_pick);
    end else begin
      case ($urandom_range(0, 9))
        0, 1:    lc = 16'd0;
        9:       lc = 16'($urandom_range(7, 24));
        default: lc = 16'($urandom_range(1, 6));
      endcase
    end
    case ($urandom_range(0, 7))
      0, 1:    le = 17'd0;
      2:       le = 17'($urandom_range(1, 255));
      3:       le = 17'd256;
      4:       le = 17'($urandom_range(257, 65535));
      5:       le = 17'd65536;
      6:       le = 17'($urandom_range(65537, 131071));
      default: le = 17'($urandom);
    endcase
    offer(ReqStart, $urandom, lc, le, 8'($urandom), -1, NoByte);
    phase_items++;
    // mostly complete commands, now and then one cut short by the next start
    n_data = lc;
    if (lc != 0 && $urandom_range(0, 9) == 0) n_data = $urandom_range(0, lc - 1);
    for (k = 0; k < n_data; k++) begin
      offer(ReqData, $urandom, 16'($urandom), 17'($urandom), 8'($urandom), -1, NoByte);
      phase_items++;
    end
    // stray data bytes with no command open
    if (n_data == lc && $urandom_range(0, 7) == 0)
      repeat ($urandom_range(1, 2)) offer(ReqData, $urandom, 16'($urandom), 17'($urandom),
                                          8'($urandom), -1, NoByte);
  endtask

  task automatic run_phase(input int budget);
    phase_items = 0;
    while (phase_items < budget) send_command(-1);
  endtask

  initial begin
    int r;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (r = 0; r < NumRows; r++) begin
      if (script[r].kind == ROW_CFG) begin
        settle();
        write_capacity(script[r].le);
      end else begin
        offer(script[r].req, script[r].hw, script[r].lc, script[r].le, script[r].dv,
              script[r].n_typed, script[r].typed);
      end
    end

    // largest capacity, with a long receiver hold-off while the sender keeps going
    settle();
    write_capacity(17'h1FFFF);
    hold_req <= hold_req + 1;
    run_phase(34);
    send_command(256 + $urandom_range(0, 3));

    settle();
    write_capacity(17'($urandom_range(4, 24)));
    run_phase(28);

    settle();
    write_capacity(17'd0);
    sender_gaps = 1'b0;
    run_phase(14);

    settle();
    write_capacity(CapacityReset);
    sender_gaps = 1'b1;
    run_phase(28);

    settle();
    write_capacity(17'($urandom_range(0, 131071)));
    run_phase(12);

    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (frame_due_q.size() != 0);
    repeat (TailCycles) @(posedge clk_i);

    $display("%0d transfers in (%0d commands, %0d rejected), %0d frame bytes out",
             n_in, n_starts, n_errors, n_out);
    $display("%0d capacity writes incl. 0 and 131071, receiver hold-off, gap-free stretch",
             n_cfg);
    if (mismatch_cnt == 0 && frame_due_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

@@ sim.f @@
design/acf_pkg.sv
design/acf_front.sv
design/acf_queue.sv
design/acf_back.sv
design/apdu_command_framer_core.sv
sim/tb_apdu_command_framer_core.sv
